// ----- hw/rtl/mssd_pkg.sv -----
package mssd_pkg;

  typedef struct packed {
    logic        op;
    logic [19:0] value;
    logic        show_point;
    logic        show_k;
    logic [23:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [6:0] segment_lines;
    logic [3:0] digit_select_n;
    logic       point_line;
    logic       busy_res;
  } out_word_t;

  localparam logic OP_SHOW = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned PROD_W     = 41;

  // floor(v / 10^k) = (v * MUL) >> SH, exact for any 20-bit v
  localparam logic [20:0] MUL_E1 = 21'd1677722;
  localparam logic [20:0] MUL_E2 = 21'd1342178;
  localparam logic [20:0] MUL_E3 = 21'd1073742;
  localparam logic [20:0] MUL_E4 = 21'd1717987;
  localparam logic [20:0] MUL_E5 = 21'd1374390;
  localparam int unsigned SH_E1  = 24;
  localparam int unsigned SH_E2  = 27;
  localparam int unsigned SH_E3  = 30;
  localparam int unsigned SH_E4  = 34;
  localparam int unsigned SH_E5  = 37;

  localparam logic [3:0]  DEC_BASE     = 4'd10;
  localparam logic [3:0]  GLYPH_K      = 4'd10;
  localparam logic [7:0]  DWELL_RESET  = 8'd3;
  localparam logic [24:0] ELAPSED_MAX  = 25'h1FF_FFFF;
  localparam logic [1:0]  LAST_DIGIT   = 2'd3;
  localparam logic [3:0]  SEL_IDLE     = 4'hF;

  function automatic logic [6:0] glyph(input logic [3:0] code);
    logic [6:0] seg;
    unique case (code)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      4'd10:   seg = 7'h75;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- hw/rtl/multiplexed_seven_segment_driver_unit.sv -----
// channel | ports                          | word
// --------+--------------------------------+----------------------------------
// in      | in_valid  in_ready  in_data    | in_word_t: op, value, flags, time
// out     | out_valid out_ready out_data   | out_word_t: segments, selects
// cfg     | cfg_we    cfg_wdata            | dwell_ms, written at once
//
// One word per cycle unless the output stalls. Stage 1 register: decimal
// digits by reciprocal multiply; output register: scan state update.
// Sync active-low reset: scan idle, selects high, segments off, dwell_ms = 3.
// A stalled output holds its word; the input stage keeps taking words while
// the output register can drain.
module multiplexed_seven_segment_driver_unit
  import mssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [19:0]        v;
  logic [PROD_W-1:0]  p1, p2, p3, p4, p5;
  logic [3:0]         q1, q2, q3, q4, q5;
  logic [3:0]         d0, d1, d2, d3, d4, d5;
  logic [3:0]         codes_in [NUM_DIGITS];

  logic               in_fire, advance;
  logic               s1_v_r, s1_op_r, s1_pt_r;
  logic [23:0]        s1_dur_r;
  logic [3:0]         s1_codes_r [NUM_DIGITS];

  logic [7:0]         dwell_r;
  logic [3:0]         codes_r [NUM_DIGITS];
  logic [3:0]         codes_nxt [NUM_DIGITS];
  logic [1:0]         cur_r, cur_nxt;
  logic [7:0]         cnt_r, cnt_nxt, cnt_inc, limit;
  logic [24:0]        elapsed_r, elapsed_nxt;
  logic [23:0]        dur_r, dur_nxt;
  logic               run_r, run_nxt;
  logic               pt_r, pt_nxt;
  logic [6:0]         seg_r, seg_nxt;
  logic               out_valid_r;
  out_word_t          out_data_r, out_data_nxt;

  assign in_fire   = in_valid && in_ready;
  assign advance   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_v_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    v  = in_data.value;
    p1 = PROD_W'(v) * PROD_W'(MUL_E1);
    p2 = PROD_W'(v) * PROD_W'(MUL_E2);
    p3 = PROD_W'(v) * PROD_W'(MUL_E3);
    p4 = PROD_W'(v) * PROD_W'(MUL_E4);
    p5 = PROD_W'(v) * PROD_W'(MUL_E5);
    q1 = p1[SH_E1 +: 4];
    q2 = p2[SH_E2 +: 4];
    q3 = p3[SH_E3 +: 4];
    q4 = p4[SH_E4 +: 4];
    q5 = p5[SH_E5 +: 4];
    // digit = q_k - 10*q_(k+1), exact in mod-16 arithmetic
    d0 = v[3:0] - q1 * DEC_BASE;
    d1 = q1 - q2 * DEC_BASE;
    d2 = q2 - q3 * DEC_BASE;
    d3 = q3 - q4 * DEC_BASE;
    d4 = q4 - q5 * DEC_BASE;
    d5 = (q5 == DEC_BASE) ? 4'd0 : q5;
    if (in_data.show_k) begin
      codes_in[0] = d5;
      codes_in[1] = d4;
      codes_in[2] = d3;
      codes_in[3] = GLYPH_K;
    end else begin
      codes_in[0] = d3;
      codes_in[1] = d2;
      codes_in[2] = d1;
      codes_in[3] = d0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
    if (in_fire) begin
      s1_op_r    <= in_data.op;
      s1_pt_r    <= in_data.show_point;
      s1_dur_r   <= in_data.duration_ms;
      s1_codes_r <= codes_in;
    end
  end

  always_comb begin
    codes_nxt   = codes_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    elapsed_nxt = elapsed_r;
    dur_nxt     = dur_r;
    run_nxt     = run_r;
    pt_nxt      = pt_r;
    seg_nxt     = seg_r;
    limit       = (dwell_r == 8'd0) ? 8'd1 : dwell_r;
    cnt_inc     = cnt_r + 8'd1;
    if (advance) begin
      unique case (s1_op_r)
        OP_SHOW: begin
          if (!run_r) begin
            codes_nxt   = s1_codes_r;
            pt_nxt      = s1_pt_r;
            dur_nxt     = s1_dur_r;
            elapsed_nxt = '0;
            cnt_nxt     = '0;
            cur_nxt     = '0;
            run_nxt     = 1'b1;
            seg_nxt     = glyph(s1_codes_r[0]);
          end
        end
        OP_TICK: begin
          if (run_r) begin
            if (elapsed_r != ELAPSED_MAX) begin
              elapsed_nxt = elapsed_r + 25'd1;
            end
            cnt_nxt = cnt_inc;
            if (cnt_inc >= limit) begin
              cnt_nxt = '0;
              if (cur_r == LAST_DIGIT) begin
                if (elapsed_nxt > {1'b0, dur_r}) begin
                  run_nxt = 1'b0;
                end else begin
                  cur_nxt = '0;
                  seg_nxt = glyph(codes_r[0]);
                end
              end else begin
                cur_nxt = cur_r + 2'd1;
                seg_nxt = glyph(codes_r[cur_nxt]);
              end
            end
          end
        end
        default: ;
      endcase
    end
    out_data_nxt.segment_lines  = seg_nxt;
    out_data_nxt.digit_select_n = run_nxt ? ~(4'd1 << cur_nxt) : SEL_IDLE;
    out_data_nxt.point_line     = pt_nxt;
    out_data_nxt.busy_res       = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r     <= DWELL_RESET;
      codes_r     <= '{default: 4'd0};
      cur_r       <= '0;
      cnt_r       <= '0;
      elapsed_r   <= '0;
      dur_r       <= '0;
      run_r       <= 1'b0;
      pt_r        <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dwell_r <= cfg_wdata;
      end
      codes_r   <= codes_nxt;
      cur_r     <= cur_nxt;
      cnt_r     <= cnt_nxt;
      elapsed_r <= elapsed_nxt;
      dur_r     <= dur_nxt;
      run_r     <= run_nxt;
      pt_r      <= pt_nxt;
      seg_r     <= seg_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- hw/rtl/mssd_checker.sv -----
module mssd_checker
  import mssd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_idle_selects_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> out_data.digit_select_n == SEL_IDLE)
    else $error("digit select active while idle");

  a_busy_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.busy_res |-> $countones(~out_data.digit_select_n) == 1)
    else $error("not exactly one digit lit while busy");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

endmodule

bind multiplexed_seven_segment_driver_unit mssd_checker u_mssd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
  import mssd_pkg::*;
();

  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned WDOG_LIMIT = 5000;
  localparam int unsigned TAIL_WAIT  = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  multiplexed_seven_segment_driver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // display model state
  logic [6:0]  seg_rom [16] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
                                7'h7F, 7'h6F, 7'h75, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
  logic [7:0]  dwell_reg = DWELL_RESET;
  logic [3:0]  digit_code [4] = '{4'd0, 4'd0, 4'd0, 4'd0};
  logic [1:0]  cur_digit = 2'd0;
  logic [7:0]  dwell_cnt = 8'd0;
  logic [24:0] elapsed = 25'd0;
  logic [23:0] dur_held = 24'd0;
  logic        showing = 1'b0;
  logic        pt_held = 1'b0;
  logic [6:0]  seg_held = 7'd0;

  out_word_t   display_exp [$];
  out_word_t   exp_word;
  int unsigned error_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        long_hold = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_cycles = 0;

  function automatic out_word_t display_next(input in_word_t w);
    out_word_t r;
    logic [7:0] lim;
    logic [19:0] v;
    v = w.value;
    lim = (dwell_reg == 8'd0) ? 8'd1 : dwell_reg;
    if (w.op == OP_SHOW) begin
      if (!showing) begin
        if (w.show_k) begin
          digit_code[3] = GLYPH_K;
          digit_code[2] = 4'((v / 1000) % 10);
          digit_code[1] = 4'((v / 10000) % 10);
          digit_code[0] = 4'((v / 100000) % 10);
        end else begin
          digit_code[3] = 4'(v % 10);
          digit_code[2] = 4'((v / 10) % 10);
          digit_code[1] = 4'((v / 100) % 10);
          digit_code[0] = 4'((v / 1000) % 10);
        end
        pt_held   = w.show_point;
        dur_held  = w.duration_ms;
        elapsed   = '0;
        dwell_cnt = '0;
        cur_digit = '0;
        showing   = 1'b1;
        seg_held  = seg_rom[digit_code[cur_digit]];
      end
    end else if (showing) begin
      if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
      dwell_cnt = dwell_cnt + 1'b1;
      if (dwell_cnt >= lim) begin
        dwell_cnt = '0;
        if (cur_digit == LAST_DIGIT) begin
          if (elapsed > {1'b0, dur_held}) begin
            showing = 1'b0;
          end else begin
            cur_digit = '0;
            seg_held  = seg_rom[digit_code[cur_digit]];
          end
        end else begin
          cur_digit = cur_digit + 1'b1;
          seg_held  = seg_rom[digit_code[cur_digit]];
        end
      end
    end
    r.segment_lines  = seg_held;
    r.digit_select_n = showing ? ~(4'b0001 << cur_digit) : SEL_IDLE;
    r.point_line     = pt_held;
    r.busy_res       = showing;
    return r;
  endfunction

  function automatic in_word_t show_word(input logic [19:0] v, input logic pt,
                                         input logic k, input logic [23:0] dur);
    in_word_t w;
    w.op          = OP_SHOW;
    w.value       = v;
    w.show_point  = pt;
    w.show_k      = k;
    w.duration_ms = dur;
    return w;
  endfunction

  function automatic in_word_t noise_word(input logic op);
    in_word_t w;
    w.op          = op;
    w.value       = 20'($urandom_range(0, 20'hFFFFF));
    w.show_point  = 1'($urandom_range(0, 1));
    w.show_k      = 1'($urandom_range(0, 1));
    w.duration_ms = 24'($urandom_range(0, 24'hFFFFFF));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = 0;
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    display_exp.insert(display_exp.size(), display_next(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (display_exp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_dwell(input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dwell_reg = d;
  endtask

  // mostly complete shows with random content, some noise words
  task automatic run_traffic(input int unsigned n);
    int unsigned done;
    int unsigned scan;
    logic [23:0] dur;
    logic [19:0] v;
    done = 0;
    while (done < n) begin
      scan = 4 * ((dwell_reg == 8'd0) ? 1 : dwell_reg);
      if (!showing) begin
        if ($urandom_range(0, 99) < 85) begin
          case ($urandom_range(0, 7))
            0:       v = 20'd0;
            1:       v = 20'hFFFFF;
            2:       v = 20'd999999;
            default: v = 20'($urandom_range(0, 20'hFFFFF));
          endcase
          if ($urandom_range(0, 9) == 0) dur = 24'($urandom_range(0, 400));
          else dur = 24'($urandom_range(0, 3 * scan));
          send_word(show_word(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dur));
          done++;
        end else begin
          send_word(noise_word(OP_TICK));
          done++;
        end
      end else if ($urandom_range(0, 99) < 90) begin
        send_word(noise_word(OP_TICK));
        done++;
      end else begin
        send_word(noise_word(OP_SHOW));
        done++;
      end
    end
  endtask

  task automatic reset_dut();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed();
    write_dwell(8'd3);
    send_word(noise_word(OP_TICK));
    send_word(show_word(20'd1234, 1'b1, 1'b0, 24'd0));
    send_word(show_word(20'hFFFFF, 1'b0, 1'b1, 24'hFFFFFF));
    repeat (12) send_word(noise_word(OP_TICK));
    send_word(noise_word(OP_TICK));
    drain();
    // zero dwell acts as one tick per digit
    write_dwell(8'd0);
    send_word(show_word(20'd999999, 1'b0, 1'b1, 24'd3));
    repeat (5) send_word(noise_word(OP_TICK));
    drain();
  endtask

  task automatic test_scan_no_idle();
    write_dwell(8'd1);
    send_gap_pct = 0;
    stall_pct <= 0;
    run_traffic(450);
    drain();
  endtask

  task automatic test_sender_gaps();
    write_dwell(8'd2);
    send_gap_pct = 85;
    stall_pct <= 0;
    run_traffic(350);
    drain();
  endtask

  task automatic test_receiver_stall();
    write_dwell(8'd0);
    send_gap_pct = 0;
    stall_pct <= 85;
    run_traffic(350);
    drain();
  endtask

  task automatic test_both_idle();
    write_dwell(8'($urandom_range(4, 9)));
    send_gap_pct = 7;
    stall_pct <= 7;
    run_traffic(300);
    drain();
  endtask

  task automatic test_output_hold();
    write_dwell(8'd1);
    send_gap_pct = 0;
    stall_pct <= 0;
    long_hold <= 1'b1;
    run_traffic(60);
    drain();
    long_hold <= 1'b0;
  endtask

  task automatic test_max_dwell();
    write_dwell(8'd255);
    send_gap_pct = 0;
    stall_pct <= 7;
    run_traffic(120);
    drain();
  endtask

  task automatic test_long_show();
    write_dwell(8'd1);
    stall_pct <= 0;
    if (!showing) send_word(show_word(20'd54321, 1'b1, 1'b0, 24'hFFFFFF));
    repeat (20) send_word(noise_word(OP_TICK));
    drain();
  endtask

  always @(posedge clk) begin
    if (long_hold && hold_cnt < HOLD_LEN) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (display_exp.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        error_count++;
      end else begin
        exp_word = display_exp.pop_front();
        if (out_data.segment_lines !== exp_word.segment_lines) begin
          $error("segment_lines: expected %h, got %h",
                 exp_word.segment_lines, out_data.segment_lines);
          error_count++;
        end
        if (out_data.digit_select_n !== exp_word.digit_select_n) begin
          $error("digit_select_n: expected %h, got %h",
                 exp_word.digit_select_n, out_data.digit_select_n);
          error_count++;
        end
        if (out_data.point_line !== exp_word.point_line) begin
          $error("point_line: expected %b, got %b",
                 exp_word.point_line, out_data.point_line);
          error_count++;
        end
        if (out_data.busy_res !== exp_word.busy_res) begin
          $error("busy_res: expected %b, got %b",
                 exp_word.busy_res, out_data.busy_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    reset_dut();
    test_directed();
    test_scan_no_idle();
    test_sender_gaps();
    test_receiver_stall();
    test_both_idle();
    test_output_hold();
    test_max_dwell();
    test_long_show();
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0 && display_exp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
